// ===== rtl/hhfe_pkg.sv =====
// ----------------------------------------------------------------------------
// hhfe_pkg
// Types, constants and codes shared by the header field extractor.
// ----------------------------------------------------------------------------
package hhfe_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int FIELD_MAX_DEF   = 4096;

  localparam logic [7:0] CR_BYTE = 8'h0D;

  localparam int OUTQ_DEPTH = 4;
  localparam int QPTR_W     = $clog2(OUTQ_DEPTH);

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [1:0] REG_PATTERN_LOW   = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH  = 2'd1;
  localparam logic [1:0] REG_PATTERN_LEN   = 2'd2;
  localparam logic [1:0] REG_MAX_FIELD_LEN = 2'd3;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_FIELD,
    PH_CLOSED,
    PH_STOPPED
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  field_byte;
    logic        is_status;
    logic [1:0]  status;
    logic [11:0] field_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== rtl/hhfe_stream_if.sv =====
// ----------------------------------------------------------------------------
// hhfe_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface hhfe_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/hhfe_match_cell.sv =====
// ----------------------------------------------------------------------------
// hhfe_match_cell
// One marker position: holds the flag "stream so far ends with marker bytes
// 0..i" and hands it to the next cell.
// ----------------------------------------------------------------------------
module hhfe_match_cell (
  input  logic               clk,
  input  logic               rst,
  input  hhfe_pkg::cell_ctl_t ctl,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         marker_byte,
  input  logic               link_in,
  output logic               hit,
  output logic               link_out
);
  import hhfe_pkg::*;

  logic flag;

  assign hit      = link_in && (data_byte == marker_byte);
  assign link_out = flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctl.clear) begin
      flag <= 1'b0;
    end else if (ctl.shift) begin
      flag <= hit;
    end
  end
endmodule

// ===== rtl/hhfe_out_queue.sv =====
// ----------------------------------------------------------------------------
// hhfe_out_queue
// Small result queue; takes up to two beats per cycle, sends one when the sink is ready.
// ----------------------------------------------------------------------------
module hhfe_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_a,
  input  hhfe_pkg::result_t item_a,
  input  logic              push_b,
  input  hhfe_pkg::result_t item_b,
  output logic              room,
  hhfe_stream_if.source     result_out
);
  import hhfe_pkg::*;

  result_t            slots [OUTQ_DEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QPTR_W:0]    count;
  logic [QPTR_W:0]    n_push;
  logic               pop;
  logic [QPTR_W-1:0]  wptr_b;

  assign pop    = result_out.valid && result_out.ready;
  assign n_push = {{QPTR_W{1'b0}}, push_a} + {{QPTR_W{1'b0}}, push_b};
  assign wptr_b = push_a ? wptr + {{(QPTR_W-1){1'b0}}, 1'b1} : wptr;
  assign room   = count <= (QPTR_W+1)'(OUTQ_DEPTH - 2);

  assign result_out.valid   = count != '0;
  assign result_out.payload = slots[rptr];

  always_ff @(posedge clk) begin
    if (push_a) begin
      slots[wptr] <= item_a;
    end
    if (push_b) begin
      slots[wptr_b] <= item_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_push[QPTR_W-1:0];
      rptr  <= rptr + {{(QPTR_W-1){1'b0}}, pop};
      count <= count + n_push - {{QPTR_W{1'b0}}, pop};
    end
  end
endmodule

// ===== rtl/http_header_field_extractor_core.sv =====
// A result beat is registered in the output queue when its byte is accepted.
// Throughput: one byte per cycle while the queue has room; the marker compare is a
// row of one cell per marker byte, each checking the input byte and neighbor's flag.
// A final byte with a field byte queues two beats; the four-entry output queue
// keeps input ready while it holds at most two beats.
// Reset: synchronous; clears match flags, phase and counters, loads register defaults.
// ----------------------------------------------------------------------------
// http_header_field_extractor_core
// Finds a configured marker in a message byte stream and forwards the field
// bytes that follow it, then a status beat at the end of the message.
// ----------------------------------------------------------------------------
module http_header_field_extractor_core #(
  parameter int PATTERN_MAX = hhfe_pkg::PATTERN_MAX_DEF,
  parameter int FIELD_MAX   = hhfe_pkg::FIELD_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  hhfe_stream_if.sink   byte_in,
  hhfe_stream_if.source result_out
);
  import hhfe_pkg::*;

  localparam int PIDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int KEEP_CAP = ((FIELD_MAX - 1) < 4095) ? (FIELD_MAX - 1) : 4095;

  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [4:0]  pattern_len;
  logic [12:0] max_field_len;

  phase_t      phase, phase_eff, phase_next;
  logic [11:0] kept_count, kept_next;
  logic        raw, raw_next;

  logic        accept;
  logic [7:0]  b;
  logic        fin;
  logic [4:0]  len_eff;
  logic [4:0]  len_m1;
  logic [12:0] lim13;
  logic [11:0] keep_lim;
  logic        marker_hit;
  logic        emit_field;
  logic        room;
  result_t     item_a, item_b;
  cell_ctl_t   cell_ctl;

  logic [127:0]           marker_bits;
  logic [PATTERN_MAX:0]   links;
  logic [PATTERN_MAX-1:0] hits;

  assign accept = byte_in.valid && byte_in.ready;
  assign b      = byte_in.payload.data_byte;
  assign fin    = byte_in.payload.last_in;
  assign byte_in.ready = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low   <= '0;
      pattern_high  <= '0;
      pattern_len   <= 5'd1;
      max_field_len <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:   pattern_low   <= cfg_data;
        REG_PATTERN_HIGH:  pattern_high  <= cfg_data;
        REG_PATTERN_LEN:   pattern_len   <= cfg_data[4:0];
        REG_MAX_FIELD_LEN: max_field_len <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign len_eff  = (pattern_len > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : pattern_len;
  assign len_m1   = len_eff - 5'd1;
  assign lim13    = (max_field_len == '0) ? 13'd0 : max_field_len - 13'd1;
  assign keep_lim = (lim13 > 13'(KEEP_CAP)) ? 12'(KEEP_CAP) : lim13[11:0];

  // marker search chain
  assign marker_bits = {pattern_high, pattern_low};
  assign links[0]    = 1'b1;

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      hhfe_match_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (cell_ctl),
        .data_byte   (b),
        .marker_byte (marker_bits[8*gi +: 8]),
        .link_in     (links[gi]),
        .hit         (hits[gi]),
        .link_out    (links[gi+1])
      );
    end
  endgenerate

  assign marker_hit = hits[len_m1[PIDX_W-1:0]];

  // phase next-state
  always_comb begin
    phase_eff = (phase == PH_SEARCH && len_eff == '0) ? PH_FIELD : phase;
    phase_next = phase_eff;
    case (phase_eff)
      PH_SEARCH: begin
        if (b == 8'd0) begin
          phase_next = PH_STOPPED;
        end else if (marker_hit) begin
          phase_next = PH_FIELD;
        end
      end
      PH_FIELD: begin
        if (b == CR_BYTE) begin
          phase_next = PH_CLOSED;
        end
      end
      default: ;
    endcase
  end

  // outputs and counters
  always_comb begin
    emit_field = (phase_eff == PH_FIELD) && (b != CR_BYTE) && (kept_count < keep_lim);
    raw_next   = raw || ((phase_eff == PH_FIELD) && (b != CR_BYTE));
    kept_next  = emit_field ? kept_count + 12'd1 : kept_count;

    cell_ctl.clear = accept && fin;
    cell_ctl.shift = accept && (phase_eff == PH_SEARCH) && (b != 8'd0);

    item_a = '0;
    item_a.field_byte = b;

    item_b = '0;
    item_b.is_status    = 1'b1;
    item_b.field_length = kept_next;
    item_b.last         = 1'b1;
    case (phase_next)
      PH_FIELD, PH_CLOSED: item_b.status = raw_next ? ST_FOUND : ST_EMPTY;
      default:             item_b.status = ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SEARCH;
      kept_count <= '0;
      raw        <= 1'b0;
    end else if (accept) begin
      if (fin) begin
        phase      <= PH_SEARCH;
        kept_count <= '0;
        raw        <= 1'b0;
      end else begin
        phase      <= phase_next;
        kept_count <= kept_next;
        raw        <= raw_next;
      end
    end
  end

  hhfe_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_a     (accept && emit_field),
    .item_a     (item_a),
    .push_b     (accept && fin),
    .item_b     (item_b),
    .room       (room),
    .result_out (result_out)
  );

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> phase == PH_SEARCH && kept_count == '0 && !raw)
    else $error("message end did not clear state");

  a_raw_phase: assert property (@(posedge clk) disable iff (rst)
    raw |-> phase != PH_SEARCH)
    else $error("field seen flag set while searching");

  a_kept_step: assert property (@(posedge clk) disable iff (rst)
    kept_count != $past(kept_count) && kept_count != '0 |->
      kept_count == $past(kept_count) + 12'd1)
    else $error("kept count jumped");
endmodule
